/* src/gcbi_pkg.sv */
`timescale 1ns / 1ps
package gcbi_pkg;
  localparam int MAX_CELLS_DEF  = 256;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int POWER_BITS_DEF = 32;
  localparam int TWO_PI_Q12     = 25736;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 15;
  localparam logic [1:0] CFG_MIN_ELEV  = 2'd0;
  localparam logic [1:0] CFG_HALF_STEP = 2'd1;
  localparam logic [1:0] CFG_CELLS     = 2'd2;
  localparam logic [1:0] ST_LOADED       = 2'd0;
  localparam logic [1:0] ST_INTERPOLATED = 2'd1;
  localparam logic [1:0] ST_BELOW_MIN    = 2'd2;
  localparam logic [1:0] ST_NO_CELL      = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_CHECK, S_MUL, S_PROD, S_DIV1, S_MUL2, S_DIV2, S_DONE
  } gcbi_state_t;

  typedef struct packed {
    logic load;      // write table, answer loaded
    logic qstart;    // latch query, prepare angles
    logic rd;        // issue table read at scan index
    logic adv;       // scan index + 1
    logic take;      // latch weights of the matching cell
    logic mul1;      // form first products
    logic div_go;    // start divider
    logic mul2;      // form second products
    logic emit;      // strobe the result
  } gcbi_cmd_t;

  typedef struct packed {
    logic below;     // query below minimum elevation
    logic hit;       // current cell contains point
    logic last;      // scan index at end
    logic div_done;
  } gcbi_sts_t;
endpackage

/* src/gcbi_divider.sv */
`timescale 1ns / 1ps
module gcbi_divider #(
  parameter int NUM_BITS = 49,
  parameter int DEN_BITS = 17
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic [NUM_BITS-1:0] quo,
  output logic                done
);
  localparam int CW = $clog2(NUM_BITS + 1);
  logic [NUM_BITS-1:0] q_r, q_nxt;
  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt, done_r, done_nxt;
  logic [DEN_BITS:0]   trial;

  // one quotient bit a cycle, restoring
  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[DEN_BITS-1:0], q_r[NUM_BITS-1]};
    if (go) begin
      q_nxt = num; rem_nxt = '0; cnt_nxt = CW'(NUM_BITS); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (go) den_r <= den;
  end

  assign quo  = q_r;
  assign done = done_r;
endmodule

/* src/gcbi_datapath.sv */
`timescale 1ns / 1ps
module gcbi_datapath #(
  parameter int MAX_CELLS  = gcbi_pkg::MAX_CELLS_DEF,
  parameter int ANGLE_BITS = gcbi_pkg::ANGLE_BITS_DEF,
  parameter int POWER_BITS = gcbi_pkg::POWER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gcbi_pkg::gcbi_cmd_t          cmd,
  output gcbi_pkg::gcbi_sts_t          sts,
  input  logic                         cfg_we,
  input  logic [gcbi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gcbi_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic [7:0]                   in_cell_index,
  input  logic signed [ANGLE_BITS-1:0] in_cell_elev_low,
  input  logic signed [ANGLE_BITS-1:0] in_cell_elev_high,
  input  logic signed [ANGLE_BITS-1:0] in_cell_azim_low,
  input  logic signed [ANGLE_BITS-1:0] in_cell_azim_high,
  input  logic [POWER_BITS-1:0]        in_corner_low_left,
  input  logic [POWER_BITS-1:0]        in_corner_low_right,
  input  logic [POWER_BITS-1:0]        in_corner_high_left,
  input  logic [POWER_BITS-1:0]        in_corner_high_right,
  input  logic signed [ANGLE_BITS-1:0] in_query_azimuth,
  input  logic signed [ANGLE_BITS-1:0] in_query_elevation,
  output logic                         out_valid,
  output logic [31:0]                  out_noise_power,
  output logic [1:0]                   out_status,
  output logic [7:0]                   out_matched_cell
);
  import gcbi_pkg::*;
  localparam int AW  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNW = $clog2(MAX_CELLS + 1);
  localparam int EA  = ANGLE_BITS + 2;           // extended angle
  localparam int WW  = ANGLE_BITS + 2;           // weight width (differences)
  localparam int SW  = WW + 1;                   // weight sum
  localparam int NW  = WW + POWER_BITS + 1;      // numerator
  localparam int BW  = 4 * ANGLE_BITS;
  localparam int CRW = 2 * POWER_BITS;

  logic [BW-1:0]  bnd_mem [MAX_CELLS];
  logic [CRW-1:0] lo_mem  [MAX_CELLS];
  logic [CRW-1:0] hi_mem  [MAX_CELLS];
  logic [BW-1:0]  bnd_q;
  logic [CRW-1:0] lo_q, hi_q;

  logic signed [13:0] min_elev_r;
  logic [14:0]        half_step_r;
  logic [8:0]         cells_r;
  logic [CNW-1:0]     idx_r, lim;
  logic signed [EA-1:0] az_r, el_r, az0;
  logic signed [EA-1:0] el_lo, el_hi, az_lo, az_hi;
  logic [WW-1:0] dx1_r, dx2_r, dy1_r, dy2_r;
  logic [NW-1:0] na_r, nb_r;
  logic [NW-1:0] p_ll, p_lr, p_hl, p_hr, p_lo, p_hi;
  logic [NW-1:0] quo_a, quo_b;
  logic da, db;
  logic [NW-1:0] num_a, num_b;
  logic [SW-1:0] den_a, den_b;
  logic [1:0]    st_r;
  logic [POWER_BITS-1:0] pw_r, pw_sat;
  logic [7:0]    mc_r;
  logic          val_r;
  logic          phase_r;
  logic          hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_elev_r <= '0; half_step_r <= '0; cells_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_ELEV:  min_elev_r  <= $signed(cfg_data[13:0]);
        CFG_HALF_STEP: half_step_r <= cfg_data;
        CFG_CELLS:     cells_r     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && (32'(in_cell_index) < MAX_CELLS)) begin
      bnd_mem[AW'(in_cell_index)] <= {in_cell_elev_low, in_cell_elev_high,
                                      in_cell_azim_low, in_cell_azim_high};
      lo_mem[AW'(in_cell_index)]  <= {in_corner_low_left, in_corner_low_right};
      hi_mem[AW'(in_cell_index)]  <= {in_corner_high_left, in_corner_high_right};
    end
    if (cmd.rd) begin
      bnd_q <= bnd_mem[idx_r[AW-1:0]];
      lo_q  <= lo_mem[idx_r[AW-1:0]];
      hi_q  <= hi_mem[idx_r[AW-1:0]];
    end
  end

  // azimuth wrap
  always_comb begin
    az0 = EA'(in_query_azimuth);
    if (az0 < 0) az0 = az0 + EA'(TWO_PI_Q12);
    if (az0 <= $signed(EA'(half_step_r))) az0 = az0 + EA'(TWO_PI_Q12);
  end

  assign lim = (32'(cells_r) > MAX_CELLS) ? CNW'(MAX_CELLS) : CNW'(cells_r);
  assign el_lo = EA'($signed(bnd_q[4*ANGLE_BITS-1 -: ANGLE_BITS]));
  assign el_hi = EA'($signed(bnd_q[3*ANGLE_BITS-1 -: ANGLE_BITS]));
  assign az_lo = EA'($signed(bnd_q[2*ANGLE_BITS-1 -: ANGLE_BITS]));
  assign az_hi = EA'($signed(bnd_q[ANGLE_BITS-1 -: ANGLE_BITS]));

  assign sts.below = (el_r < EA'(min_elev_r));
  assign sts.hit   = (el_lo < el_r) && (el_r < el_hi) && (az_lo < az_r) && (az_r < az_hi);
  assign sts.last  = (idx_r >= lim);
  assign sts.div_done = da && db;

  // weighted corner products, first pass from the cell, second from the quotients
  assign p_ll = NW'(dx2_r) * NW'(lo_q[CRW-1 -: POWER_BITS]);
  assign p_lr = NW'(dx1_r) * NW'(lo_q[POWER_BITS-1:0]);
  assign p_hl = NW'(dx2_r) * NW'(hi_q[CRW-1 -: POWER_BITS]);
  assign p_hr = NW'(dx1_r) * NW'(hi_q[POWER_BITS-1:0]);
  assign p_lo = NW'(dy2_r) * NW'(quo_a[POWER_BITS-1:0]);
  assign p_hi = NW'(dy1_r) * NW'(quo_b[POWER_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.qstart) begin
      az_r <= az0; el_r <= EA'(in_query_elevation); idx_r <= '0; hit_r <= 1'b0;
    end else if (cmd.adv) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.take) begin
      dx1_r <= WW'(az_r - az_lo); dx2_r <= WW'(az_hi - az_r);
      dy1_r <= WW'(el_r - el_lo); dy2_r <= WW'(el_hi - el_r);
      hit_r <= 1'b1;
    end
    if (cmd.mul1) begin
      na_r <= p_ll + p_lr;
      nb_r <= p_hl + p_hr;
      phase_r <= 1'b0;
    end
    if (cmd.mul2) begin
      na_r <= p_lo + p_hi;
      phase_r <= 1'b1;
    end
  end

  assign num_a = na_r;
  assign num_b = nb_r;
  assign den_a = phase_r ? (SW'(dy1_r) + SW'(dy2_r)) : (SW'(dx1_r) + SW'(dx2_r));
  assign den_b = SW'(dx1_r) + SW'(dx2_r);

  gcbi_divider #(.NUM_BITS(NW), .DEN_BITS(SW)) u_div_a (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .num(num_a), .den(den_a),
    .quo(quo_a), .done(da));
  gcbi_divider #(.NUM_BITS(NW), .DEN_BITS(SW)) u_div_b (
    .clk(clk), .rst_n(rst_n), .go(cmd.div_go), .num(num_b), .den(den_b),
    .quo(quo_b), .done(db));

  assign pw_sat = (quo_a > NW'({POWER_BITS{1'b1}})) ? {POWER_BITS{1'b1}}
                                                     : POWER_BITS'(quo_a);

  always_ff @(posedge clk) begin
    if (!rst_n) val_r <= 1'b0;
    else        val_r <= cmd.emit || cmd.load;
    if (cmd.load) begin
      st_r <= ST_LOADED; pw_r <= '0; mc_r <= in_cell_index;
    end else if (cmd.emit) begin
      if (hit_r) begin
        st_r <= ST_INTERPOLATED; pw_r <= pw_sat; mc_r <= 8'(idx_r);
      end else begin
        st_r <= sts.below ? ST_BELOW_MIN : ST_NO_CELL;
        pw_r <= '0; mc_r <= '0;
      end
    end
  end

  assign out_valid        = val_r;
  assign out_noise_power  = 32'(pw_r);
  assign out_status       = st_r;
  assign out_matched_cell = mc_r;
endmodule

/* src/gcbi_controller.sv */
`timescale 1ns / 1ps
module gcbi_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_mode,
  input  gcbi_pkg::gcbi_sts_t sts,
  output gcbi_pkg::gcbi_cmd_t cmd,
  output logic                busy
);
  import gcbi_pkg::*;
  gcbi_state_t state_r, state_nxt;
  logic ph_r, ph_nxt; // 0 first divide, 1 second

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r;
    unique case (state_r)
      S_IDLE:  if (start && in_mode) state_nxt = S_READ;
      S_READ:  state_nxt = S_CHECK;
      S_CHECK: begin
        if (sts.below || sts.last) state_nxt = S_DONE;
        else                       state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = sts.hit ? S_PROD : S_READ;
      S_PROD:  state_nxt = S_DIV2;
      S_DIV1:  begin
        if (sts.div_done) begin
          state_nxt = ph_r ? S_DONE : S_MUL2;
          ph_nxt = 1'b1;
        end
      end
      S_MUL2:  state_nxt = S_DIV2;
      S_DIV2:  state_nxt = S_DIV1;
      S_DONE:  begin state_nxt = S_IDLE; ph_nxt = 1'b0; end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  begin
        cmd.load   = start && !in_mode;
        cmd.qstart = start && in_mode;
      end
      S_READ:  cmd.rd = 1'b1;
      S_CHECK: ;
      S_MUL:   begin
        cmd.take = sts.hit;
        cmd.adv  = !sts.hit;
      end
      S_PROD:  cmd.mul1 = 1'b1;
      S_DIV1:  ;
      S_MUL2:  cmd.mul2 = 1'b1;
      S_DIV2:  cmd.div_go = 1'b1;
      S_DONE:  cmd.emit = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ph_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ph_r <= ph_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

/* src/grid_cell_bilinear_interpolator.sv */
`timescale 1ns / 1ps
// Grid-cell bilinear interpolator.
// Input items: pulse start while busy is low. in_mode 0 loads a cell into
// entry in_cell_index; in_mode 1 queries the power at an azimuth/elevation.
// Results: out_valid strobes for one cycle with out_noise_power, out_status
// and out_matched_cell. The receiver cannot stall; take it on the strobe.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Timing: a load answers the cycle after acceptance and leaves the block
// ready at once. A query scans the table cell by cell (memory read,
// compare, step). A match then runs the products and two passes of a
// bit-serial divider before the strobe. A search that finds nothing
// strobes when the scan reaches the configured cell count; a query below
// the minimum elevation strobes without comparing any cell.
// One item at a time; for a query busy stays high until the result strobe.
// Reset clears the configuration registers, out_valid, the divider
// control and the controller; table contents are not cleared and a cell
// must be loaded before a query may search it.
module grid_cell_bilinear_interpolator #(
  parameter int MAX_CELLS  = gcbi_pkg::MAX_CELLS_DEF,
  parameter int ANGLE_BITS = gcbi_pkg::ANGLE_BITS_DEF,
  parameter int POWER_BITS = gcbi_pkg::POWER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [7:0]                   in_cell_index,
  input  logic signed [ANGLE_BITS-1:0] in_cell_elev_low,
  input  logic signed [ANGLE_BITS-1:0] in_cell_elev_high,
  input  logic signed [ANGLE_BITS-1:0] in_cell_azim_low,
  input  logic signed [ANGLE_BITS-1:0] in_cell_azim_high,
  input  logic [POWER_BITS-1:0]        in_corner_low_left,
  input  logic [POWER_BITS-1:0]        in_corner_low_right,
  input  logic [POWER_BITS-1:0]        in_corner_high_left,
  input  logic [POWER_BITS-1:0]        in_corner_high_right,
  input  logic signed [ANGLE_BITS-1:0] in_query_azimuth,
  input  logic signed [ANGLE_BITS-1:0] in_query_elevation,
  input  logic                         cfg_we,
  input  logic [gcbi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gcbi_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                         out_valid,
  output logic [31:0]                  out_noise_power,
  output logic [1:0]                   out_status,
  output logic [7:0]                   out_matched_cell
);
  import gcbi_pkg::*;
  gcbi_cmd_t cmd;
  gcbi_sts_t sts;

  // controller sequences scan and divide; datapath holds table and maths
  gcbi_controller u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_mode(in_mode),
    .sts(sts), .cmd(cmd), .busy(busy));

  gcbi_datapath #(.MAX_CELLS(MAX_CELLS), .ANGLE_BITS(ANGLE_BITS),
                  .POWER_BITS(POWER_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_cell_index(in_cell_index),
    .in_cell_elev_low(in_cell_elev_low), .in_cell_elev_high(in_cell_elev_high),
    .in_cell_azim_low(in_cell_azim_low), .in_cell_azim_high(in_cell_azim_high),
    .in_corner_low_left(in_corner_low_left), .in_corner_low_right(in_corner_low_right),
    .in_corner_high_left(in_corner_high_left),
    .in_corner_high_right(in_corner_high_right),
    .in_query_azimuth(in_query_azimuth), .in_query_elevation(in_query_elevation),
    .out_valid(out_valid), .out_noise_power(out_noise_power),
    .out_status(out_status), .out_matched_cell(out_matched_cell));
endmodule

/* src/gcbi_checker.sv */
`timescale 1ns / 1ps
module gcbi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [31:0] out_noise_power,
  input logic [1:0] out_status
);
  import gcbi_pkg::*;
  a_pw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_INTERPOLATED |-> out_noise_power == 32'd0)
    else $error("power not zero");
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("item lost");
  a_no_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(!busy) |-> $past(start))
    else $error("invented result");
endmodule

bind grid_cell_bilinear_interpolator gcbi_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_noise_power(out_noise_power), .out_status(out_status));
